FILE: src/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_CMP = 3'd4;

  localparam logic [2:0] REL_LT = 3'd0;
  localparam logic [2:0] REL_GT = 3'd1;
  localparam logic [2:0] REL_LE = 3'd2;
  localparam logic [2:0] REL_GE = 3'd3;
  localparam logic [2:0] REL_EQ = 3'd4;
  localparam logic [2:0] REL_NE = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_FORM,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: src/rau_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module rau_mul #(
  parameter int WIDTH = 17
) (
  input  logic                        clk,
  input  logic signed [WIDTH-1:0]     a,
  input  logic signed [WIDTH-1:0]     b,
  output logic signed [2*WIDTH-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: src/rau_gcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_gcd
// Iterative binary gcd, one subtract or shift step per cycle.
// ----------------------------------------------------------------------------
module rau_gcd #(
  parameter int WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [WIDTH-1:0]        a,
  input  logic [WIDTH-1:0]        b,
  output logic [WIDTH-1:0]        g,
  output rau_pkg::unit_stat_t     stat
);
  import rau_pkg::*;

  localparam int KW = $clog2(WIDTH);

  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] y;
  logic [KW-1:0]    k;
  logic             busy;
  logic             done;
  logic             x_ge;
  logic [WIDTH-1:0] diff;

  assign x_ge = (x >= y);
  assign diff = x_ge ? (x - y) : (y - x);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (x == '0 || y == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= a;
      y <= b;
      k <= '0;
    end else if (busy) begin
      if (x == '0 || y == '0) begin
        g <= (x | y) << k;
      end else if (!x[0] && !y[0]) begin
        x <= x >> 1;
        y <= y >> 1;
        k <= k + KW'(1);
      end else if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x_ge) begin
        x <= diff >> 1;
      end else begin
        y <= diff >> 1;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: src/rau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
  parameter int WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [WIDTH-1:0]        dividend,
  input  logic [WIDTH-1:0]        divisor,
  output logic [WIDTH-1:0]        quotient,
  output rau_pkg::unit_stat_t     stat
);
  import rau_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH:0]   rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  assign shifted = {rem[WIDTH-1:0], quo[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[WIDTH-2:0], !diff[WIDTH]};
      rem <= diff[WIDTH] ? shifted : diff;
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: src/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply, divide or compare two fractions, result reduced
// by the gcd. One shared multiplier, an iterative gcd and a shared divider.
// ----------------------------------------------------------------------------
// sequencing: error beats go from idle straight to the finish state; compare
//   beats pass the three multiply states and the form state; arithmetic beats
//   with a nonzero numerator also run the binary gcd loop and two bit-serial
//   divisions of 2*OPERAND_WIDTH bits; one beat is in progress at a time
// a finished beat waits in the output register while the next one is taken
// reset: synchronous, clears the sequencer and the output valid
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // a_num, a_den, b_num, b_den
  input  logic [((4*OPERAND_WIDTH-2)+7)/8*8-1:0]    s_tdata,
  // action, relation
  input  logic [5:0]                                s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // res_num, res_den
  output logic [63:0]                               m_tdata,
  // compare_true, status
  output logic [2:0]                                m_tuser
);
  import rau_pkg::*;

  localparam int W   = OPERAND_WIDTH;
  localparam int MOP = W + 1;
  localparam int PW  = 2 * MOP;
  localparam int MW  = 2 * W;
  localparam int SW  = (MW > 33) ? MW : 33;
  localparam int AD0 = W;
  localparam int BN0 = 2 * W - 1;
  localparam int BD0 = 3 * W - 1;

  state_t state;
  state_t state_next;

  logic [2:0]             action;
  logic [2:0]             relation;
  logic signed [W-1:0]    an;
  logic signed [W-1:0]    bn;
  logic [W-2:0]           ad;
  logic [W-2:0]           bd;

  logic signed [MOP-1:0]  mul_a;
  logic signed [MOP-1:0]  mul_b;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   p1;
  logic signed [PW-1:0]   p2;

  logic [MW-1:0]          mag;
  logic [MW-1:0]          udn;
  logic                   neg;
  logic                   cmp;
  logic [1:0]             status;
  logic [MW-1:0]          g_reg;

  logic                   gcd_start;
  logic [MW-1:0]          gcd_g;
  unit_stat_t             gcd_stat;
  logic                   div_start;
  logic [MW-1:0]          div_dividend;
  logic [MW-1:0]          div_divisor;
  logic [MW-1:0]          div_quo;
  unit_stat_t             div_stat;

  logic                   accept;
  logic                   in_bad_act;
  logic                   in_zero_den;
  logic                   in_div_zero;
  logic [2:0]             in_action;
  logic signed [W-1:0]    in_bn;
  logic [W-2:0]           in_ad;
  logic [W-2:0]           in_bd;

  logic signed [PW-1:0]   num_f;
  logic signed [PW-1:0]   num_abs;
  logic signed [PW-1:0]   den_abs;
  logic                   rel_true;
  logic                   load_out;

  logic [SW-1:0]          mag_w;
  logic [SW-1:0]          mag_sat;
  logic [SW-1:0]          udn_w;
  logic [SW-1:0]          udn_sat;
  logic [31:0]            num_out;

  assign in_action   = s_tuser[2:0];
  assign in_bn       = s_tdata[BN0 +: W];
  assign in_ad       = s_tdata[AD0 +: W-1];
  assign in_bd       = s_tdata[BD0 +: W-1];
  assign accept      = s_tvalid && s_tready;
  assign in_bad_act  = (in_action > ACT_CMP);
  assign in_zero_den = (in_ad == '0) || (in_bd == '0);
  assign in_div_zero = (in_action == ACT_DIV) && (in_bn == '0);
  assign load_out    = !m_tvalid || m_tready;

  rau_mul #(.WIDTH(MOP)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // operands are taken straight from the formed fraction at start
  rau_gcd #(.WIDTH(MW)) u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a     (num_abs[MW-1:0]),
    .b     (den_abs[MW-1:0]),
    .g     (gcd_g),
    .stat  (gcd_stat)
  );

  rau_div #(.WIDTH(MW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (in_bad_act || in_zero_den || in_div_zero) begin
            state_next = S_FIN;
          end else begin
            state_next = S_MUL1;
          end
        end
      end
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_MUL3;
      S_MUL3: state_next = S_FORM;
      S_FORM: begin
        if (action == ACT_CMP || num_abs == '0) begin
          state_next = S_FIN;
        end else begin
          state_next = S_GCD;
        end
      end
      S_GCD: if (gcd_stat.done) state_next = S_DIVN;
      S_DIVN: if (div_stat.done) state_next = S_DIVD;
      S_DIVD: if (div_stat.done) state_next = S_FIN;
      S_FIN: if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready     = 1'b0;
    gcd_start    = 1'b0;
    div_start    = 1'b0;
    div_dividend = mag;
    div_divisor  = gcd_g;
    mul_a        = {an[W-1], an};
    mul_b        = {2'b00, bd};
    case (state)
      S_IDLE: s_tready = 1'b1;
      S_MUL1: begin
        mul_a = {an[W-1], an};
        mul_b = (action == ACT_MUL) ? {bn[W-1], bn} : {2'b00, bd};
      end
      S_MUL2: begin
        mul_a = {bn[W-1], bn};
        mul_b = {2'b00, ad};
      end
      S_MUL3: begin
        mul_a = {2'b00, ad};
        mul_b = (action == ACT_DIV) ? {bn[W-1], bn} : {2'b00, bd};
      end
      S_FORM: gcd_start = (action != ACT_CMP) && (num_abs != '0);
      S_GCD: div_start = gcd_stat.done;
      S_DIVN: begin
        div_start    = div_stat.done;
        div_dividend = udn;
        div_divisor  = g_reg;
      end
      default: ;
    endcase
  end

  // forming the raw fraction and the compare
  always_comb begin
    case (action)
      ACT_ADD: num_f = p1 + p2;
      ACT_SUB: num_f = p1 - p2;
      default: num_f = p1;
    endcase
    num_abs = num_f[PW-1] ? -num_f : num_f;
    den_abs = prod[PW-1] ? -prod : prod;
    case (relation)
      REL_LT:  rel_true = (p1 < p2);
      REL_GT:  rel_true = (p1 > p2);
      REL_LE:  rel_true = (p1 <= p2);
      REL_GE:  rel_true = (p1 >= p2);
      REL_EQ:  rel_true = (p1 == p2);
      REL_NE:  rel_true = (p1 != p2);
      default: rel_true = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        action   <= s_tuser[2:0];
        relation <= s_tuser[5:3];
        an       <= s_tdata[W-1:0];
        ad       <= in_ad;
        bn       <= in_bn;
        bd       <= in_bd;
        mag      <= '0;
        udn      <= '0;
        neg      <= 1'b0;
        cmp      <= 1'b0;
        if (in_bad_act) begin
          status <= ST_OK;
        end else if (in_zero_den) begin
          status <= ST_ZERO_DEN;
        end else if (in_div_zero) begin
          status <= ST_DIV_ZERO;
        end else begin
          status <= ST_OK;
        end
      end
      S_MUL2: p1 <= prod;
      S_MUL3: p2 <= prod;
      S_FORM: begin
        if (action == ACT_CMP) begin
          cmp <= rel_true;
        end else if (num_abs == '0) begin
          udn <= MW'(1);
        end else begin
          mag <= num_abs[MW-1:0];
          udn <= den_abs[MW-1:0];
          neg <= num_f[PW-1] ^ prod[PW-1];
        end
      end
      S_GCD: if (gcd_stat.done) g_reg <= gcd_g;
      S_DIVN: if (div_stat.done) mag <= div_quo;
      S_DIVD: if (div_stat.done) udn <= div_quo;
      default: ;
    endcase
  end

  // saturation into the output ranges
  always_comb begin
    mag_w = SW'(mag);
    udn_w = SW'(udn);
    if (neg) begin
      mag_sat = (mag_w > SW'(33'h0_8000_0000)) ? SW'(33'h0_8000_0000) : mag_w;
    end else begin
      mag_sat = (mag_w > SW'(33'h0_7FFF_FFFF)) ? SW'(33'h0_7FFF_FFFF) : mag_w;
    end
    udn_sat = (udn_w > SW'(33'h0_4000_0000)) ? SW'(33'h0_4000_0000) : udn_w;
    num_out = neg ? (32'd0 - mag_sat[31:0]) : mag_sat[31:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_FIN && load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && load_out) begin
      m_tdata <= {1'b0, udn_sat[30:0], num_out};
      m_tuser <= {status, cmp};
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken while a beat is in progress");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(gcd_stat.busy && div_stat.busy))
    else $error("gcd and divider busy together");

  a_error_no_compare: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2:1] != ST_OK) |-> (!m_tuser[0] && m_tdata[62:0] == '0))
    else $error("error beat carries a result");

  a_nonzero_has_den: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[31:0] != '0) |-> (m_tdata[62:32] != '0))
    else $error("nonzero numerator with zero denominator");

endmodule
